>>> sv/qtaa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree atlas tile allocator package
// Shared widths, codes and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package qtaa_pkg;

   localparam int LEVEL_W    = 5;
   localparam int FSL_W      = 4;
   localparam int SLOT_W     = 6;
   localparam int QUARTER_W  = 3;
   localparam int TILE_X_W   = 15;
   localparam int TILE_Y_W   = 20;
   localparam int SIDE_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RESTART  = 1'b1;

   localparam logic CSR_FULL_SIZE_LOG2 = 1'b0;
   localparam logic CSR_SLOT_COUNT     = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [QUARTER_W-1:0] NO_PARENT     = 3'd4;
   localparam logic [QUARTER_W-1:0] FIRST_QUARTER = 3'd1;
   localparam logic [SLOT_W-1:0]    MAX_SLOTS     = 6'd32;
   localparam logic [FSL_W-1:0]     FSL_RESET     = 4'd12;

   typedef struct packed {
      logic load;
      logic climb;
      logic commit;
   } qtaa_cmd_type;

   typedef struct packed {
      logic resolved;
      logic out_free;
   } qtaa_status_type;

endpackage
`default_nettype wire

>>> sv/qtaa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree atlas tile allocator controller
// Takes a request, lets the datapath climb the levels until the request is
// resolved, and commits the result once the output register is free.
// ----------------------------------------------------------------------------
module qtaa_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output qtaa_pkg::qtaa_cmd_type        cmd,
   input  wire qtaa_pkg::qtaa_status_type status
);
   import qtaa_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.climb  = (state_ff == ST_EVAL) && !status.resolved;
      cmd.commit = (state_ff == ST_EVAL) && status.resolved && status.out_free;
      req_ready  = (state_ff == ST_IDLE);
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/qtaa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree atlas tile allocator datapath
// Holds the configuration, the per-level parent positions and quarter counts,
// the climb index and the output register.
// ----------------------------------------------------------------------------
module qtaa_dp #(
   parameter int LEVELS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic                                csr_index,
   input  wire logic [qtaa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire logic                                req_command,
   input  wire logic [qtaa_pkg::LEVEL_W-1:0]        req_level,
   input  wire qtaa_pkg::qtaa_cmd_type              cmd,
   output qtaa_pkg::qtaa_status_type                status,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [qtaa_pkg::TILE_X_W-1:0]            rsp_tile_x,
   output logic [qtaa_pkg::TILE_Y_W-1:0]            rsp_tile_y,
   output logic [qtaa_pkg::SIDE_W-1:0]              rsp_tile_side,
   output logic [qtaa_pkg::STATUS_W-1:0]            rsp_status
);
   import qtaa_pkg::*;

   localparam int LW = $clog2(LEVELS);
   localparam logic [LEVEL_W:0] LEVEL_LIMIT = (LEVEL_W + 1)'(LEVELS);

   logic [FSL_W-1:0]     fsl_ff, fsl_in;
   logic [SLOT_W-1:0]    slot_count_ff, slot_count_in;
   logic                 command_ff, command_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LW-1:0]        j_ff, j_in;
   logic [SLOT_W-1:0]    next_slot_ff, next_slot_in;
   logic [TILE_X_W-1:0]  parent_x_ff [LEVELS];
   logic [TILE_X_W-1:0]  parent_x_in [LEVELS];
   logic [TILE_Y_W-1:0]  parent_y_ff [LEVELS];
   logic [TILE_Y_W-1:0]  parent_y_in [LEVELS];
   logic [QUARTER_W-1:0] quarters_ff [LEVELS];
   logic [QUARTER_W-1:0] quarters_in [LEVELS];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TILE_X_W-1:0]  tile_x_ff, tile_x_in;
   logic [TILE_Y_W-1:0]  tile_y_ff, tile_y_in;
   logic [SIDE_W-1:0]    side_ff, side_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic [SIDE_W-1:0]    full_side;
   logic [SIDE_W-1:0]    side_j;
   logic [QUARTER_W-1:0] quarter_j;
   logic                 no_parent;
   logic                 bad_level;
   logic [SLOT_W-1:0]    slot_limit;
   logic                 atlas_full;
   logic                 grant;
   logic                 is_restart;
   logic [LW-1:0]        level_idx;
   logic [TILE_Y_W:0]    slot_y_wide;
   logic [TILE_X_W-1:0]  new_x;
   logic [TILE_Y_W-1:0]  new_y;

   always_comb begin
      full_side   = SIDE_W'(1) << fsl_ff;
      side_j      = full_side >> j_ff;
      quarter_j   = quarters_ff[j_ff];
      no_parent   = quarter_j[2];
      is_restart  = (command_ff == CMD_RESTART);
      bad_level   = ({1'b0, level_ff} >= LEVEL_LIMIT) ||
                    (level_ff > LEVEL_W'(fsl_ff));
      slot_limit  = (slot_count_ff > MAX_SLOTS) ? MAX_SLOTS : slot_count_ff;
      atlas_full  = (next_slot_ff >= slot_limit);
      level_idx   = level_ff[LW-1:0];
      slot_y_wide = (TILE_Y_W + 1)'(next_slot_ff) << fsl_ff;
      grant       = !is_restart && !bad_level && !(no_parent && atlas_full);
      if (no_parent) begin
         new_x = '0;
         new_y = slot_y_wide[TILE_Y_W-1:0];
      end else begin
         new_x = parent_x_ff[j_ff] + (quarter_j[1] ? TILE_X_W'(side_j) : '0);
         new_y = parent_y_ff[j_ff] + (quarter_j[0] ? TILE_Y_W'(side_j) : '0);
      end
      status.resolved = is_restart || bad_level || !no_parent || (j_ff == '0);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      fsl_in        = fsl_ff;
      slot_count_in = slot_count_ff;
      command_in    = command_ff;
      level_in      = level_ff;
      j_in          = j_ff;
      next_slot_in  = next_slot_ff;
      parent_x_in   = parent_x_ff;
      parent_y_in   = parent_y_ff;
      quarters_in   = quarters_ff;
      tile_x_in     = tile_x_ff;
      tile_y_in     = tile_y_ff;
      side_in       = side_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_FULL_SIZE_LOG2: fsl_in = csr_write_data[FSL_W-1:0];
            CSR_SLOT_COUNT:     slot_count_in = csr_write_data[SLOT_W-1:0];
            default: begin
               fsl_in = fsl_ff;
            end
         endcase
      end

      if (cmd.load) begin
         command_in = req_command;
         level_in   = req_level;
         j_in       = LW'(req_level);
      end

      if (cmd.climb) begin
         j_in = j_ff - LW'(1);
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         tile_x_in    = '0;
         tile_y_in    = '0;
         side_in      = '0;
         status_in    = STATUS_OK;
         if (is_restart) begin
            for (int i = 0; i < LEVELS; i++) begin
               quarters_in[i] = NO_PARENT;
            end
            next_slot_in = '0;
         end else if (bad_level) begin
            status_in = STATUS_RANGE;
         end else if (!grant) begin
            status_in = STATUS_FULL;
         end else begin
            if (no_parent) begin
               next_slot_in = next_slot_ff + SLOT_W'(1);
            end else begin
               quarters_in[j_ff] = quarter_j + QUARTER_W'(1);
            end
            for (int i = 0; i < LEVELS; i++) begin
               if ((LW'(i) > j_ff) && (LW'(i) <= level_idx)) begin
                  parent_x_in[i] = new_x;
                  parent_y_in[i] = new_y;
                  quarters_in[i] = FIRST_QUARTER;
               end
            end
            tile_x_in = new_x;
            tile_y_in = new_y;
            side_in   = full_side >> level_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsl_ff        <= FSL_RESET;
         slot_count_ff <= MAX_SLOTS;
         next_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            quarters_ff[i] <= NO_PARENT;
         end
      end else begin
         fsl_ff        <= fsl_in;
         slot_count_ff <= slot_count_in;
         next_slot_ff  <= next_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
         quarters_ff   <= quarters_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff  <= command_in;
      level_ff    <= level_in;
      j_ff        <= j_in;
      parent_x_ff <= parent_x_in;
      parent_y_ff <= parent_y_in;
      tile_x_ff   <= tile_x_in;
      tile_y_ff   <= tile_y_in;
      side_ff     <= side_in;
      status_ff   <= status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tile_x    = tile_x_ff;
   assign rsp_tile_y    = tile_y_ff;
   assign rsp_tile_side = side_ff;
   assign rsp_status    = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("Committed transaction did not reach the output register.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != STATUS_OK) |-> (side_ff == '0))
      else $error("Failed transaction carries a non-zero tile side.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && is_restart |=> (next_slot_ff == '0) && (quarters_ff[0] == NO_PARENT))
      else $error("Restart did not clear the allocator state.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.climb |-> (j_ff != '0) && no_parent)
      else $error("Climb issued past the root or past a free parent.");

   assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= MAX_SLOTS)
      else $error("Slot counter ran beyond the atlas limit.");

endmodule
`default_nettype wire

>>> sv/quadtree_atlas_tile_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadtree atlas tile allocator
// Hands out square tiles of a one-column shadow atlas by quadtree levels,
// taking new parents from the level above and new slots at the root.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Content
// req_      in         req_valid/req_ready   command, level
// rsp_      out        rsp_valid/rsp_ready   tile_x, tile_y, tile_side, status
// csr_      in         csr_write_enable      register index and write data
//
// A transaction is accepted in the idle state and then climbs the per-level
// quarter counts in evaluation, one level at a time, until it resolves; the
// next is accepted only after its commit, and a valid level never exceeds 15.
// Restart and out-of-range transactions resolve in the first evaluation
// cycle. A stalled output holds the result back at its commit and blocks the
// input meanwhile. Reset is synchronous and empties every level and the slot
// counter.
// ----------------------------------------------------------------------------
module quadtree_atlas_tile_allocator #(
   parameter int LEVELS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [qtaa_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_command,
   input  wire logic [qtaa_pkg::LEVEL_W-1:0]    req_level,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [qtaa_pkg::TILE_X_W-1:0]        rsp_tile_x,
   output logic [qtaa_pkg::TILE_Y_W-1:0]        rsp_tile_y,
   output logic [qtaa_pkg::SIDE_W-1:0]          rsp_tile_side,
   output logic [qtaa_pkg::STATUS_W-1:0]        rsp_status
);
   import qtaa_pkg::*;

   qtaa_cmd_type    cmd;
   qtaa_status_type status;

   qtaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   qtaa_dp #(
      .LEVELS (LEVELS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_level        (req_level),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_tile_x       (rsp_tile_x),
      .rsp_tile_y       (rsp_tile_y),
      .rsp_tile_side    (rsp_tile_side),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire

>>> sim/quadtree_atlas_tile_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadtree atlas tile allocator testbench
// Drives allocate and restart transactions through the request channel and
// keeps a behavioural copy of the quadtree state to predict each tile. Every
// response is compared field by field with the oldest prediction. Directed
// geometry corners come first, then randomised phases with idle gaps and
// back-pressure, including one long output stall that fills the block.
// ----------------------------------------------------------------------------
module quadtree_atlas_tile_allocator_tb;
   import qtaa_pkg::*;

   localparam int LEVELS      = 32;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [TILE_X_W-1:0] tile_x;
      logic [TILE_Y_W-1:0] tile_y;
      logic [SIDE_W-1:0]   tile_side;
      logic [STATUS_W-1:0] status;
   } tile_grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_index = CSR_FULL_SIZE_LOG2;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_command = CMD_ALLOCATE;
   logic [LEVEL_W-1:0]    req_level = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [TILE_X_W-1:0]   rsp_tile_x;
   logic [TILE_Y_W-1:0]   rsp_tile_y;
   logic [SIDE_W-1:0]     rsp_tile_side;
   logic [STATUS_W-1:0]   rsp_status;

   logic [TILE_X_W-1:0]   anchor_x [LEVELS];
   logic [TILE_Y_W-1:0]   anchor_y [LEVELS];
   logic [QUARTER_W-1:0]  quarters_taken [LEVELS];
   logic [SLOT_W-1:0]     next_free_slot;
   logic [FSL_W-1:0]      slot_side_log2;
   logic [SLOT_W-1:0]     slots_configured;

   tile_grant_type expected_grants [$];
   tile_grant_type oldest_grant;

   int fail_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic rsp_hold = 1'b0;
   int transactions_sent = 0;
   int restarts_sent = 0;
   int full_refusals = 0;
   int range_refusals = 0;
   int geometries_used = 0;

   quadtree_atlas_tile_allocator #(.LEVELS(LEVELS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tile_x       (rsp_tile_x),
      .rsp_tile_y       (rsp_tile_y),
      .rsp_tile_side    (rsp_tile_side),
      .rsp_status       (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   function automatic void clear_quadtree();
      for (int i = 0; i < LEVELS; i++) begin
         anchor_x[i] = '0;
         anchor_y[i] = '0;
         quarters_taken[i] = NO_PARENT;
      end
      next_free_slot = '0;
   endfunction

   function automatic tile_grant_type allocate_tile(logic command, logic [LEVEL_W-1:0] level);
      tile_grant_type grant;
      int unsigned full_side, slot_limit, top, side, quarter, x, y, i;
      grant = '0;
      if (command == CMD_RESTART) begin
         clear_quadtree();
         restarts_sent++;
         return grant;
      end
      if (level >= LEVELS || level > slot_side_log2) begin
         grant.status = STATUS_RANGE;
         range_refusals++;
         return grant;
      end
      full_side = 32'd1 << slot_side_log2;
      slot_limit = (slots_configured > MAX_SLOTS) ? 32'(MAX_SLOTS) : 32'(slots_configured);
      top = 32'(level);
      while (top > 0 && quarters_taken[top] >= NO_PARENT)
         top--;
      if (quarters_taken[top] < NO_PARENT) begin
         quarter = 32'(quarters_taken[top]);
         side = full_side >> top;
         x = 32'(anchor_x[top]) + (quarter >> 1) * side;
         y = 32'(anchor_y[top]) + (quarter & 32'd1) * side;
         quarters_taken[top] = QUARTER_W'(quarter + 32'd1);
      end else begin
         if (32'(next_free_slot) >= slot_limit) begin
            grant.status = STATUS_FULL;
            full_refusals++;
            return grant;
         end
         x = 32'd0;
         y = 32'(next_free_slot) * full_side;
         next_free_slot = next_free_slot + SLOT_W'(1);
      end
      x = x & 32'h7FFF;
      y = y & 32'hFFFFF;
      for (i = top + 32'd1; i <= 32'(level); i++) begin
         anchor_x[i] = TILE_X_W'(x);
         anchor_y[i] = TILE_Y_W'(y);
         quarters_taken[i] = FIRST_QUARTER;
      end
      grant.tile_x = TILE_X_W'(x);
      grant.tile_y = TILE_Y_W'(y);
      grant.tile_side = SIDE_W'(full_side >> level);
      grant.status = STATUS_OK;
      return grant;
   endfunction

   always @(negedge clock) begin
      if (rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= 32'(receiver_stall_pct));
   end

   task automatic check_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            $error("response with no transaction outstanding: x %0d y %0d side %0d status %0d",
                   rsp_tile_x, rsp_tile_y, rsp_tile_side, rsp_status);
            fail_count++;
         end else begin
            oldest_grant = expected_grants.pop_front();
            check_field("tile_x", 32'(oldest_grant.tile_x), 32'(rsp_tile_x));
            check_field("tile_y", 32'(oldest_grant.tile_y), 32'(rsp_tile_y));
            check_field("tile_side", 32'(oldest_grant.tile_side), 32'(rsp_tile_side));
            check_field("status", 32'(oldest_grant.status), 32'(rsp_status));
         end
      end
   end

   task automatic send_request(logic command, logic [LEVEL_W-1:0] level);
      tile_grant_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < 32'(sender_idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_level <= level;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predicted = allocate_tile(command, level);
      expected_grants = {expected_grants, predicted};
      transactions_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_grants.size() != 0)
         @(posedge clock);
      repeat (LEVELS + 4) @(posedge clock);
   endtask

   task automatic set_geometry(logic [FSL_W-1:0] side_log2, logic [SLOT_W-1:0] slots);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_FULL_SIZE_LOG2;
      csr_write_data <= CSR_DATA_W'(side_log2);
      @(posedge clock);
      slot_side_log2 = side_log2;
      @(negedge clock);
      csr_index <= CSR_SLOT_COUNT;
      csr_write_data <= slots;
      @(posedge clock);
      slots_configured = slots;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      geometries_used++;
   endtask

   task automatic send_random_requests(int count);
      int pick;
      logic [LEVEL_W-1:0] level;
      int unsigned depth;
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(99));
         level = LEVEL_W'($urandom_range(31));
         depth = $urandom_range(slot_side_log2 < 3 ? 32'(slot_side_log2) : 32'd3);
         if (pick < 3)
            send_request(CMD_RESTART, level);
         else if (pick < 9)
            send_request(CMD_ALLOCATE, level);
         else if (pick < 55)
            send_request(CMD_ALLOCATE, LEVEL_W'($urandom_range(32'(slot_side_log2))));
         else
            send_request(CMD_ALLOCATE, LEVEL_W'(32'(slot_side_log2) - depth));
      end
   endtask

   task automatic test_reset_geometry();
      send_request(CMD_ALLOCATE, 5'd0);
      repeat (5) send_request(CMD_ALLOCATE, 5'd1);
      send_request(CMD_ALLOCATE, 5'd12);
      send_request(CMD_ALLOCATE, 5'd13);
      send_request(CMD_ALLOCATE, 5'd31);
      send_request(CMD_RESTART, 5'd31);
      send_request(CMD_ALLOCATE, 5'd2);
   endtask

   task automatic test_geometry_extremes();
      set_geometry(4'd15, 6'd63);
      send_request(CMD_ALLOCATE, 5'd15);
      send_request(CMD_ALLOCATE, 5'd0);
      send_request(CMD_ALLOCATE, 5'd1);
      set_geometry(4'd0, 6'd1);
      send_request(CMD_RESTART, 5'd0);
      send_request(CMD_ALLOCATE, 5'd0);
      send_request(CMD_ALLOCATE, 5'd0);
      send_request(CMD_ALLOCATE, 5'd1);
      set_geometry(4'd4, 6'd0);
      send_request(CMD_RESTART, 5'd0);
      send_request(CMD_ALLOCATE, 5'd0);
      send_request(CMD_ALLOCATE, 5'd3);
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct,
                                    logic [FSL_W-1:0] side_log2, logic [SLOT_W-1:0] slots);
      set_geometry(side_log2, slots);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      send_random_requests(140);
   endtask

   task automatic test_output_backpressure();
      set_geometry(4'd10, 6'd32);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      send_random_requests(40);
   endtask

   initial begin
      slot_side_log2 = FSL_RESET;
      slots_configured = MAX_SLOTS;
      clear_quadtree();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_geometry_extremes();
      test_random_phase(0, 0, 4'd12, 6'd32);
      test_random_phase(73, 0, 4'd15, 6'd63);
      test_random_phase(0, 73, 4'd3, 6'd2);
      test_random_phase(31, 31, 4'd6, 6'd5);
      test_random_phase(0, 0, 4'd0, 6'd1);
      test_output_backpressure();
      settle();

      $display("Sent %0d transactions over %0d register settings: %0d restarts,",
               transactions_sent, geometries_used, restarts_sent);
      $display("%0d refused as atlas full and %0d as level out of range.",
               full_refusals, range_refusals);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
